@@ hdl/assert_macros.svh @@
// assert_macros.svh: assertion macros used by the RGB to HSV converter top level.
// Standalone header with no dependencies; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg)
`define CHK_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ hdl/rgbhsv_pkg.sv @@
// rgbhsv_pkg: widths, constants and payload types of the RGB to HSV converter.
// No dependencies; used by rgbhsv_div and rgb_to_hsv_converter_unit.
`default_nettype none

package rgbhsv_pkg;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;
    localparam int PCT_W  = 13;
    localparam int Y_W    = 13;

    localparam int DIV_NUM_W = 21;
    localparam int DIV_DEN_W = 8;
    localparam int DIV_QUO_W = 13;

    localparam logic [HUE_W-1:0] HUE_TURN  = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
    localparam logic [PCT_W-1:0] PCT_FULL  = 13'd6400;

    localparam logic [DIV_NUM_W-1:0] HUE_SLOPE = 21'd3840;
    localparam logic [DIV_NUM_W-1:0] PCT_SCALE = 21'd6400;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_in;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } t_out;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        t_sector        sector;
        logic           neg;
        logic           gray;
        logic           blk;
        logic [Y_W-1:0] y;
    } t_side;

endpackage

`default_nettype wire

@@ hdl/rgbhsv_div.sv @@
// rgbhsv_div: pipelined restoring divider, one quotient bit per register stage.
// Depends on rgbhsv_pkg for its default widths.
`default_nettype none

module rgbhsv_div
    import rgbhsv_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W,
    parameter int QUO_W = DIV_QUO_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo,
    output logic                  o_rem_nz
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    logic [NUM_W-1:0] src_rem [QUO_W];
    logic [DEN_W-1:0] src_den [QUO_W];
    logic [QUO_W-1:0] src_quo [QUO_W];
    logic [NUM_W-1:0] n_rem   [QUO_W];
    logic [QUO_W-1:0] n_quo   [QUO_W];

    always_comb begin
        logic [CMP_W-1:0] trial;
        logic             take;
        src_rem[0] = i_num;
        src_den[0] = i_den;
        src_quo[0] = '0;
        for (int j = 1; j < QUO_W; j++) begin
            src_rem[j] = r_rem[j-1];
            src_den[j] = r_den[j-1];
            src_quo[j] = r_quo[j-1];
        end
        for (int j = 0; j < QUO_W; j++) begin
            trial    = CMP_W'(src_den[j]) << (QUO_W - 1 - j);
            take     = CMP_W'(src_rem[j]) >= trial;
            n_rem[j] = take ? NUM_W'(CMP_W'(src_rem[j]) - trial) : src_rem[j];
            n_quo[j] = src_quo[j] | (QUO_W'(take) << (QUO_W - 1 - j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QUO_W; j++) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= src_den[j];
                r_quo[j] <= n_quo[j];
            end
        end
    end

    assign o_quo    = r_quo[QUO_W-1];
    assign o_rem_nz = |r_rem[QUO_W-1];

endmodule

`default_nettype wire

@@ hdl/rgb_to_hsv_converter_unit.sv @@
// rgb_to_hsv_converter_unit: top level of the 8-bit RGB to HSV converter.
// Depends on rgbhsv_pkg, rgbhsv_div and assert_macros.svh.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_in_data  (t_in)
//   result    out        o_out_valid / i_out_ready  o_out_data (t_out)
//
// One transaction is accepted per cycle while o_in_ready is high; its result passes through
// the stage 0, 1 and 2 registers, the divider stages and the output register in turn.
// Most of the depth comes from the two 13-stage dividers, one quotient bit per stage.
// A skid register behind the output stage lets the pipeline take a further transaction
// while a result waits; o_in_ready falls only once that skid register is full.
// Reset is synchronous and clears the valid bits, including the skid register's valid flag.
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsv_converter_unit
    import rgbhsv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int NSTG = DIV_QUO_W + 4;
    localparam int LAST = NSTG - 1;

    logic [NSTG-1:0] r_vld;
    logic            r_skid_vld;
    t_out            r_skid;
    t_out            r_out;
    logic            en;

    // Stage 0: largest and smallest channel and hue sector.
    logic [CHAN_W-1:0] n_hi, n_lo, n_pos, n_neg;
    t_sector           n_sector;
    logic [CHAN_W-1:0] r_s0_hi, r_s0_lo, r_s0_pos, r_s0_neg;
    t_sector           r_s0_sector;

    // Stage 1: spread, signed channel difference and scaled maximum.
    logic [CHAN_W-1:0] r_s1_hi, r_s1_diff, r_s1_abs;
    logic              r_s1_neg;
    t_sector           r_s1_sector;
    logic [Y_W-1:0]    r_s1_y;

    // Stage 2: divider operands.
    logic [DIV_NUM_W-1:0] r_s2_numh, r_s2_nums;
    logic [CHAN_W-1:0]    r_s2_diff, r_s2_hi;
    t_side                r_s2_side;

    t_side                r_sb [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] hue_quo, sat_quo;
    logic                 hue_nz;

    t_side            sb;
    logic [HUE_W-1:0] mag, base;
    logic [Y_W-1:0]   v_t;
    t_out             n_out;

    assign en         = !r_skid_vld;
    assign o_in_ready = en;

    always_comb begin
        if (i_in_data.red >= i_in_data.green && i_in_data.red >= i_in_data.blue) begin
            n_sector = SEC_RED;
            n_hi     = i_in_data.red;
            n_pos    = i_in_data.green;
            n_neg    = i_in_data.blue;
        end else if (i_in_data.green >= i_in_data.blue) begin
            n_sector = SEC_GREEN;
            n_hi     = i_in_data.green;
            n_pos    = i_in_data.blue;
            n_neg    = i_in_data.red;
        end else begin
            n_sector = SEC_BLUE;
            n_hi     = i_in_data.blue;
            n_pos    = i_in_data.red;
            n_neg    = i_in_data.green;
        end
        n_lo = (i_in_data.red < i_in_data.green) ? i_in_data.red : i_in_data.green;
        if (i_in_data.blue < n_lo) begin
            n_lo = i_in_data.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_hi     <= n_hi;
            r_s0_lo     <= n_lo;
            r_s0_pos    <= n_pos;
            r_s0_neg    <= n_neg;
            r_s0_sector <= n_sector;

            r_s1_hi     <= r_s0_hi;
            r_s1_diff   <= r_s0_hi - r_s0_lo;
            r_s1_neg    <= r_s0_pos < r_s0_neg;
            r_s1_abs    <= (r_s0_pos < r_s0_neg) ? r_s0_neg - r_s0_pos : r_s0_pos - r_s0_neg;
            r_s1_sector <= r_s0_sector;
            r_s1_y      <= (Y_W'(r_s0_hi) << 4) + (Y_W'(r_s0_hi) << 3) + Y_W'(r_s0_hi);

            r_s2_numh        <= DIV_NUM_W'(r_s1_abs) * HUE_SLOPE;
            r_s2_nums        <= DIV_NUM_W'(r_s1_diff) * PCT_SCALE;
            r_s2_diff        <= r_s1_diff;
            r_s2_hi          <= r_s1_hi;
            r_s2_side.sector <= r_s1_sector;
            r_s2_side.neg    <= r_s1_neg;
            r_s2_side.gray   <= r_s1_diff == '0;
            r_s2_side.blk    <= r_s1_hi == '0;
            r_s2_side.y      <= r_s1_y;

            r_sb[0] <= r_s2_side;
            for (int j = 1; j < DIV_QUO_W; j++) begin
                r_sb[j] <= r_sb[j-1];
            end

            r_out <= n_out;
        end
        if (en && r_vld[LAST] && !i_out_ready) begin
            r_skid <= r_out;
        end
    end

    rgbhsv_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W),
        .QUO_W (DIV_QUO_W)
    ) u_div_hue (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r_s2_numh),
        .i_den    (r_s2_diff),
        .o_quo    (hue_quo),
        .o_rem_nz (hue_nz)
    );

    rgbhsv_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W),
        .QUO_W (DIV_QUO_W)
    ) u_div_sat (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r_s2_nums),
        .i_den    (r_s2_hi),
        .o_quo    (sat_quo),
        .o_rem_nz ()
    );

    always_comb begin
        sb  = r_sb[DIV_QUO_W-1];
        mag = HUE_W'(hue_quo) + HUE_W'(sb.neg & hue_nz);
        case (sb.sector)
            SEC_RED:   base = sb.neg ? HUE_TURN : '0;
            SEC_GREEN: base = HUE_GREEN;
            SEC_BLUE:  base = HUE_BLUE;
            default:   base = '0;
        endcase
        n_out.hue        = sb.gray ? '0 : (sb.neg ? base - mag : base + mag);
        n_out.saturation = sb.blk ? '0 : PCT_W'(sat_quo);
        v_t              = sb.y + (sb.y >> 8) + Y_W'(1);
        n_out.brightness = PCT_W'(sb.y + (v_t >> 8));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_skid_vld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTG-2:0], i_in_valid};
                if (r_vld[LAST] && !i_out_ready) begin
                    r_skid_vld <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_skid_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_vld[LAST] | r_skid_vld;
    assign o_out_data  = r_skid_vld ? r_skid : r_out;

    `CHK_ASSERT(a_out_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.hue < HUE_TURN && o_out_data.saturation <= PCT_FULL && o_out_data.brightness <= PCT_FULL), "result field out of range")
    `CHK_ASSERT(a_skid_freeze, i_clk, i_rst_n, r_skid_vld |=> $stable(r_vld), "pipeline moved while skid register full")
    `CHK_ASSERT(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_vld) |-> $past(r_vld[LAST] && !i_out_ready), "skid register filled without a stalled result")

endmodule

`default_nettype wire

@@ bench/tb_rgb_to_hsv_converter_unit.sv @@
// Self-checking testbench for rgb_to_hsv_converter_unit: a directed table of pixels, then random
// pixels, each result checked against a typed expectation or a predictor of the hue, saturation and value arithmetic.
// Depends on rgbhsv_pkg for the payload types and on the RTL of the converter alone.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter_unit
    import rgbhsv_pkg::*;
();

    localparam int unsigned TURN_X64    = 23040;
    localparam int unsigned SIXTY_X64   = 3840;
    localparam int unsigned RED_BASE    = 23040;
    localparam int unsigned GREEN_BASE  = 7680;
    localparam int unsigned BLUE_BASE   = 15360;
    localparam int unsigned PERCENT_X64 = 6400;
    localparam int unsigned CHAN_MAX    = 255;

    localparam int NUM_DIRECTED  = 22;
    localparam int RANDOM_PIXELS = 1600;
    localparam int DRAIN_CYCLES  = 40;
    localparam int IDLE_LIMIT    = 2000;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_COMB,
        SINK_CHOKE
    } t_sink_mode;

    typedef struct packed {
        logic typed;
        t_in  px;
        t_out want;
    } t_pixel_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in        i_in_data   = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out       o_out_data;

    logic       pix_typed = 1'b0;
    t_out       pix_want  = '0;

    t_out       hsv_expected [$];
    int         err_count     = 0;
    int         pixels_taken  = 0;
    int         results_seen  = 0;
    int         idle_cycles   = 0;
    int         burst_left    = 0;

    t_sink_mode sink_mode  = SINK_OPEN;
    int         sink_left  = 0;
    logic [7:0] sink_phase = '0;

    // Typed expectations: black, white, the primaries, and the three two-way ties.
    t_pixel_row directed_pixels [0:NUM_DIRECTED-1] = '{
        {1'b1, 8'd0,   8'd0,   8'd0,   15'd0,     13'd0,    13'd0},
        {1'b1, 8'd255, 8'd255, 8'd255, 15'd0,     13'd0,    13'd6400},
        {1'b1, 8'd255, 8'd0,   8'd0,   15'd0,     13'd6400, 13'd6400},
        {1'b1, 8'd0,   8'd255, 8'd0,   15'd7680,  13'd6400, 13'd6400},
        {1'b1, 8'd0,   8'd0,   8'd255, 15'd15360, 13'd6400, 13'd6400},
        {1'b1, 8'd255, 8'd255, 8'd0,   15'd3840,  13'd6400, 13'd6400},
        {1'b1, 8'd255, 8'd0,   8'd255, 15'd19200, 13'd6400, 13'd6400},
        {1'b1, 8'd0,   8'd255, 8'd255, 15'd11520, 13'd6400, 13'd6400},
        {1'b0, 8'd1,   8'd1,   8'd1,   41'd0},
        {1'b0, 8'd1,   8'd0,   8'd0,   41'd0},
        {1'b0, 8'd0,   8'd1,   8'd0,   41'd0},
        {1'b0, 8'd0,   8'd0,   8'd1,   41'd0},
        {1'b0, 8'd255, 8'd254, 8'd0,   41'd0},
        {1'b0, 8'd255, 8'd0,   8'd254, 41'd0},
        {1'b0, 8'd254, 8'd255, 8'd0,   41'd0},
        {1'b0, 8'd0,   8'd254, 8'd255, 41'd0},
        {1'b0, 8'd254, 8'd0,   8'd255, 41'd0},
        {1'b0, 8'd128, 8'd128, 8'd127, 41'd0},
        {1'b0, 8'd170, 8'd85,  8'd51,  41'd0},
        {1'b0, 8'd85,  8'd170, 8'd204, 41'd0},
        {1'b0, 8'd255, 8'd255, 8'd254, 41'd0},
        {1'b0, 8'd1,   8'd255, 8'd0,   41'd0}
    };

    rgb_to_hsv_converter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out hsv_of(input t_in px);
        int unsigned r, g, b, top, bot, span, pos, neg, base, acc, quo;
        t_out res;
        r = 32'(px.red);
        g = 32'(px.green);
        b = 32'(px.blue);
        top = r;
        bot = r;
        if (g > top) top = g;
        if (b > top) top = b;
        if (g < bot) bot = g;
        if (b < bot) bot = b;
        span = top - bot;
        res = '0;
        if (span != 0) begin
            if (top == r) begin
                pos = g;
                neg = b;
                base = RED_BASE;
            end else if (top == g) begin
                pos = b;
                neg = r;
                base = GREEN_BASE;
            end else begin
                pos = r;
                neg = g;
                base = BLUE_BASE;
            end
            acc = base * span + SIXTY_X64 * pos - SIXTY_X64 * neg;
            quo = (acc / span) % TURN_X64;
            res.hue = quo[HUE_W-1:0];
        end
        if (top != 0) begin
            quo = (span * PERCENT_X64) / top;
            res.saturation = quo[PCT_W-1:0];
        end
        quo = (top * PERCENT_X64) / CHAN_MAX;
        res.brightness = quo[PCT_W-1:0];
        return res;
    endfunction

    // A random pixel is a corner case five times in sixteen: grey, tied maxima, tiny and saturated values.
    function automatic t_in random_pixel();
        t_in px;
        logic [7:0] hi, lo;
        int kind;
        kind = $urandom_range(0, 15);
        hi = 8'($urandom_range(0, 255));
        lo = 8'($urandom_range(0, 32'(hi)));
        px.red   = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue  = 8'($urandom_range(0, 255));
        case (kind)
            0: begin
                px = {hi, hi, hi};
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: px = {hi, hi, lo};
                    1: px = {hi, lo, hi};
                    default: px = {lo, hi, hi};
                endcase
            end
            2: begin
                px.red   = 8'($urandom_range(0, 3));
                px.green = 8'($urandom_range(0, 3));
                px.blue  = 8'($urandom_range(0, 3));
            end
            3: begin
                px.red   = 8'($urandom_range(252, 255));
                px.green = 8'($urandom_range(252, 255));
                px.blue  = 8'($urandom_range(252, 255));
            end
            4: begin
                case ($urandom_range(0, 5))
                    0: px = {8'd255, 8'd0, hi};
                    1: px = {8'd255, hi, 8'd0};
                    2: px = {8'd0, 8'd255, hi};
                    3: px = {hi, 8'd255, 8'd0};
                    4: px = {8'd0, hi, 8'd255};
                    default: px = {hi, 8'd0, 8'd255};
                endcase
            end
            default: begin
            end
        endcase
        return px;
    endfunction

    // Entered and left at a falling edge; valid stays high across back-to-back transactions.
    task automatic send_pixel(input t_in px, input logic typed, input t_out want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        pix_typed  <= typed;
        pix_want   <= want;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(20, 200);
        end else begin
            sink_left <= sink_left - 1;
        end
        sink_phase <= sink_phase + 8'd1;
        case (sink_mode)
            SINK_OPEN:  i_out_ready <= 1'b1;
            SINK_COIN:  i_out_ready <= ($urandom_range(0, 1) == 1);
            SINK_COMB:  i_out_ready <= ((sink_phase % 7) < 3);
            SINK_CHOKE: i_out_ready <= (sink_phase[4:0] >= 5'd24);
            default:    i_out_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                hsv_expected.push_back(pix_typed ? pix_want : hsv_of(i_in_data));
                pixels_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (hsv_expected.size() == 0) begin
                    $display("%0t: result with no transaction outstanding: hue %0d sat %0d val %0d",
                             $time, o_out_data.hue, o_out_data.saturation,
                             o_out_data.brightness);
                    err_count++;
                end else begin
                    want = hsv_expected.pop_front();
                    if (o_out_data.hue !== want.hue) begin
                        $display("%0t: hue expected %0d, got %0d",
                                 $time, want.hue, o_out_data.hue);
                        err_count++;
                    end
                    if (o_out_data.saturation !== want.saturation) begin
                        $display("%0t: saturation expected %0d, got %0d",
                                 $time, want.saturation, o_out_data.saturation);
                        err_count++;
                    end
                    if (o_out_data.brightness !== want.brightness) begin
                        $display("%0t: brightness expected %0d, got %0d",
                                 $time, want.brightness, o_out_data.brightness);
                        err_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("rgb_to_hsv_converter_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_in px;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_pixel(directed_pixels[i].px, directed_pixels[i].typed,
                       directed_pixels[i].want);
        end
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            px = random_pixel();
            send_pixel(px, 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        while (hsv_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d directed and %0d random pixels; %0d transactions taken.",
                 NUM_DIRECTED, RANDOM_PIXELS, pixels_taken);
        $display("Compared %0d results field by field; %0d mismatches.",
                 results_seen, err_count);
        if (err_count == 0) begin
            $display("rgb_to_hsv_converter_unit verification clean");
        end else begin
            $display("rgb_to_hsv_converter_unit verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/rgbhsv_pkg.sv
hdl/rgbhsv_div.sv
hdl/rgb_to_hsv_converter_unit.sv
bench/tb_rgb_to_hsv_converter_unit.sv
